// ===== rtl/atcc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// atcc_pkg
// Shared types, codes and tables for the ANSI text console cursor block.
// ============================================================================
package atcc_pkg;

    // Default geometry of the character grid
    localparam int DEF_COLUMNS = 128;
    localparam int DEF_ROWS    = 64;

    // Command queue between parser and cursor engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Packed result data width: col 7 + row 6 + glyph 7 + fore 32 + back 32, byte padded
    localparam int OUT_FIELDS_W = 84;
    localparam int OUT_DATA_W   = 88;

    // Color defaults
    localparam logic [31:0] FORE_RESET = 32'hFFCC_CCCC;
    localparam logic [31:0] BACK_RESET = 32'h0000_0000;

    // Byte codes
    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_NL    = 8'h0A;
    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;
    localparam logic [7:0] BYTE_CSI   = 8'h5B;  // '['
    localparam logic [7:0] BYTE_SGR   = 8'h6D;  // 'm'
    localparam logic [7:0] BYTE_ED    = 8'h4A;  // 'J'
    localparam logic [7:0] BYTE_HIGH  = 8'h80;
    localparam logic [6:0] GLYPH_SPACE = 7'h20;
    localparam logic [6:0] GLYPH_ESC   = 7'h1B;

    // Escape parameter values
    localparam logic [7:0] SGR_RESET   = 8'd0;
    localparam logic [7:0] SGR_FG_LO   = 8'd30;
    localparam logic [7:0] SGR_FG_HI   = 8'd37;
    localparam logic [7:0] SGR_BG_LO   = 8'd40;
    localparam logic [7:0] SGR_BG_HI   = 8'd47;
    localparam logic [7:0] SGR_FGB_LO  = 8'd90;
    localparam logic [7:0] SGR_FGB_HI  = 8'd97;
    localparam logic [7:0] SGR_BGB_LO  = 8'd100;
    localparam logic [7:0] SGR_BGB_HI  = 8'd107;
    localparam logic [7:0] ED_ALL      = 8'd2;
    localparam logic [7:0] PARAM_MAX   = 8'd255;

    // Configuration register indexes
    localparam logic [7:0] REG_TEXT_COLOR = 8'd0;
    localparam logic [7:0] REG_BACK_COLOR = 8'd1;

    // Result kinds
    localparam logic [1:0] KIND_CELL   = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Escape parser state
    typedef enum logic [1:0] {
        PH_TEXT,
        PH_ESC,
        PH_CSI
    } phase_t;

    // Cursor engine operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CHAR,
        OP_NL,
        OP_BS,
        OP_TAB,
        OP_CLEAR
    } op_t;

    // Cursor engine step within one command
    typedef enum logic [1:0] {
        ST_HEAD,
        ST_PRE_SCROLL,
        ST_MAIN,
        ST_MAIN_SCROLL
    } stage_t;

    // One queued command: optional lone-ESC cell, then the operation
    typedef struct packed {
        logic        esc_pre;
        op_t         op;
        logic [6:0]  glyph;
        logic [31:0] fore;
        logic [31:0] back;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  cell_col;
        logic [5:0]  cell_row;
        logic [6:0]  glyph_code;
        logic [31:0] fore_color;
        logic [31:0] back_color;
        logic        last_of_run;
    } res_t;

    // 16-entry color palette
    function automatic logic [31:0] palette(input logic [3:0] idx);
        logic [31:0] c;
        begin
            unique case (idx)
                4'd0:    c = 32'h0000_0000;
                4'd1:    c = 32'h00AA_0000;
                4'd2:    c = 32'h0000_AA00;
                4'd3:    c = 32'h00AA_5500;
                4'd4:    c = 32'h0000_00AA;
                4'd5:    c = 32'h00AA_00AA;
                4'd6:    c = 32'h0000_AAAA;
                4'd7:    c = 32'h00AA_AAAA;
                4'd8:    c = 32'h0055_5555;
                4'd9:    c = 32'h00FF_5555;
                4'd10:   c = 32'h0055_FF55;
                4'd11:   c = 32'h00FF_FF55;
                4'd12:   c = 32'h0055_55FF;
                4'd13:   c = 32'h00FF_55FF;
                4'd14:   c = 32'h0055_FFFF;
                default: c = 32'hFFFF_FFFF;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== rtl/ansi_text_console_cursor.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ansi_text_console_cursor
// Text stream to grid commands: cursor, colors and ANSI escape parsing.
// ============================================================================
// Bytes enter at one per cycle while the command queue is not full. A parser
// decodes ESC [ n m color changes and ESC [ 2 J clears and turns other
// non-zero text bytes into commands; a four-entry command queue feeds the
// cursor engine, which emits one cell-write, scroll or clear result per cycle
// through a registered output when not stalled. Bytes that give no result
// (escape bytes, color changes, zero bytes) never reach the engine; a
// newline that does not scroll takes an engine step with no result. A tab
// gives up to five results: up to four spaces and a scroll. A lone ESC adds
// a result for its own cell and a scroll when that cell wraps at the bottom
// row; the byte after it then takes an engine step of its own, even a zero
// byte or a newline that gives no result. The engine's one-result-per-cycle
// output, when not stalled, sets the sustained rate; the queue absorbs short
// bursts before the input stalls. The configuration port is always ready;
// the user must write it only while idle; the block does not enforce this.
module ansi_text_console_cursor
    import atcc_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // byte input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] in_byte
    // result output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [6:0] cell_col, [12:7] cell_row,
                                                  // [19:13] glyph_code, [51:20] fore_color,
                                                  // [83:52] back_color, [87:84] zero
    output logic [1:0]            m_axis_tuser,   // [1:0] kind
    output logic                  m_axis_tlast,   // last_of_run
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    logic push, pop, q_full, q_not_empty;
    cmd_t push_cmd, head;
    res_t res;

    assign cfg_ready = 1'b1;

    // Parser
    atcc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Command queue
    atcc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .not_empty(q_not_empty),
        .head     (head)
    );

    // Cursor engine
    atcc_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(q_not_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // Pack result fields, lowest first
    assign m_axis_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                           res.back_color, res.fore_color, res.glyph_code,
                           res.cell_row, res.cell_col};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last_of_run;

endmodule

// ===== rtl/atcc_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// atcc_front
// Byte parser: escape sequences, color state and classification of bytes
// into cursor commands.
// ============================================================================
module atcc_front
    import atcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // incoming bytes
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    // configuration writes
    input  logic        cfg_valid,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // command queue
    input  logic        q_full,
    output logic        push,
    output cmd_t        push_cmd
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  num_reg,   num_next;
    logic [31:0] fore_reg,  fore_next;
    logic [31:0] back_reg,  back_next;

    logic        accept;
    logic        is_digit;
    logic [11:0] num_wide;
    logic [11:0] num_acc;
    op_t         byte_op;
    logic [6:0]  byte_glyph;

    // Operation for a plain text byte
    function automatic op_t classify(input logic [7:0] c);
        op_t o;
        begin
            if (c == BYTE_NUL)
                o = OP_NONE;
            else if (c == BYTE_NL)
                o = OP_NL;
            else if (c == BYTE_BS)
                o = OP_BS;
            else if (c == BYTE_TAB)
                o = OP_TAB;
            else
                o = OP_CHAR;
            return o;
        end
    endfunction

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign is_digit   = (in_byte >= BYTE_ZERO) && (in_byte <= BYTE_NINE);
    assign byte_op    = classify(in_byte);
    assign byte_glyph = (in_byte >= BYTE_HIGH) ? GLYPH_SPACE : in_byte[6:0];

    // Decimal accumulate: n*10 + digit
    assign num_wide = 12'(num_reg);
    assign num_acc  = (num_wide << 3) + (num_wide << 1) + 12'(in_byte - BYTE_ZERO);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
            num_reg   <= '0;
            fore_reg  <= FORE_RESET;
            back_reg  <= BACK_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            num_reg   <= num_next;
            fore_reg  <= fore_next;
            back_reg  <= back_next;
        end
    end

    // Parser next state and command
    always_comb
    begin
        phase_next       = phase_reg;
        num_next         = num_reg;
        fore_next        = fore_reg;
        back_next        = back_reg;
        push             = 1'b0;
        push_cmd.esc_pre = 1'b0;
        push_cmd.op      = byte_op;
        push_cmd.glyph   = byte_glyph;
        push_cmd.fore    = fore_reg;
        push_cmd.back    = back_reg;

        // register writes
        if (cfg_valid)
        begin
            if (cfg_index == REG_TEXT_COLOR)
                fore_next = cfg_data;
            else if (cfg_index == REG_BACK_COLOR)
                back_next = cfg_data;
        end

        if (accept)
        begin
            unique case (phase_reg)
                PH_CSI:
                begin
                    if (is_digit)
                    begin
                        num_next = (num_acc > 12'(PARAM_MAX)) ? PARAM_MAX : num_acc[7:0];
                    end
                    else
                    begin
                        // final byte
                        if (in_byte == BYTE_SGR)
                        begin
                            if (num_reg == SGR_RESET)
                            begin
                                fore_next = FORE_RESET;
                                back_next = BACK_RESET;
                            end
                            else if (num_reg >= SGR_FG_LO && num_reg <= SGR_FG_HI)
                                fore_next = palette(4'(num_reg - SGR_FG_LO));
                            else if (num_reg >= SGR_FGB_LO && num_reg <= SGR_FGB_HI)
                                fore_next = palette(4'(num_reg - SGR_FGB_LO) | 4'd8);
                            else if (num_reg >= SGR_BG_LO && num_reg <= SGR_BG_HI)
                                back_next = palette(4'(num_reg - SGR_BG_LO));
                            else if (num_reg >= SGR_BGB_LO && num_reg <= SGR_BGB_HI)
                                back_next = palette(4'(num_reg - SGR_BGB_LO) | 4'd8);
                        end
                        else if (in_byte == BYTE_ED && num_reg == ED_ALL)
                        begin
                            push        = 1'b1;
                            push_cmd.op = OP_CLEAR;
                        end
                        phase_next = PH_TEXT;
                        num_next   = '0;
                    end
                end
                PH_ESC:
                begin
                    if (in_byte == BYTE_CSI)
                    begin
                        phase_next = PH_CSI;
                        num_next   = '0;
                    end
                    else if (in_byte == BYTE_ESC)
                    begin
                        // earlier ESC drawn, new one starts a sequence
                        push           = 1'b1;
                        push_cmd.op    = OP_CHAR;
                        push_cmd.glyph = GLYPH_ESC;
                        phase_next     = PH_ESC;
                    end
                    else
                    begin
                        // lone ESC cell, then this byte as text
                        push             = 1'b1;
                        push_cmd.esc_pre = 1'b1;
                        phase_next       = PH_TEXT;
                    end
                end
                PH_TEXT:
                begin
                    if (in_byte == BYTE_ESC)
                        phase_next = PH_ESC;
                    else
                        push = (byte_op != OP_NONE);
                end
                default:
                begin
                    phase_next = PH_TEXT;
                end
            endcase
        end
    end

endmodule

// ===== rtl/atcc_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// atcc_queue
// Short command FIFO between the parser and the cursor engine.
// ============================================================================
module atcc_queue
    import atcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t head
);

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/atcc_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// atcc_back
// Cursor engine: runs queued commands, moves the cursor, wraps and scrolls,
// and drives one result per cycle, when not stalled, into an output register.
// ============================================================================
module atcc_back
    import atcc_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic clk,
    input  logic rst_n,
    // command queue head
    input  logic head_valid,
    input  cmd_t head,
    output logic pop,
    // result output
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_XW = COL_W + 7;
    localparam int ROW_XW = ROW_W + 6;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    stage_t           stage_reg, stage_next;
    logic [1:0]       tab_reg, tab_next;
    logic             out_valid_reg;
    res_t             out_res_reg;

    logic             emit, done, fire, slot_free;
    logic [1:0]       out_kind_next;
    logic [COL_W-1:0] out_col_next;
    logic [ROW_W-1:0] out_row_next;
    logic [6:0]       out_glyph_next;
    logic             out_last_next;
    logic [COL_XW-1:0] col_ext;
    logic [ROW_XW-1:0] row_ext;

    logic [COL_W:0]   col_inc;
    logic             wrap;
    logic             at_bottom;
    logic             pre_step, main_step;
    logic             put_end;

    // Does the main operation give a result from the given row
    function automatic logic produces(input op_t o, input logic [ROW_W-1:0] r);
        begin
            return (o != OP_NONE) && !((o == OP_NL) && (r != ROW_W'(ROWS - 1)));
        end
    endfunction

    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign wrap      = (col_inc == (COL_W+1)'(COLUMNS));
    assign at_bottom = (row_reg == ROW_W'(ROWS - 1));
    assign pre_step  = (stage_reg == ST_HEAD) && head.esc_pre;
    assign main_step = ((stage_reg == ST_HEAD) && !head.esc_pre) || (stage_reg == ST_MAIN);
    assign put_end   = (head.op == OP_CHAR) || (tab_reg == 2'd3) || wrap;

    assign slot_free = !out_valid_reg || out_ready;
    assign fire      = head_valid && (!emit || slot_free);
    assign pop       = fire && done;

    // Command step: one result at most per cycle
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        stage_next     = stage_reg;
        tab_next       = tab_reg;
        emit           = 1'b0;
        done           = 1'b0;
        out_kind_next  = KIND_CELL;
        out_col_next   = col_reg;
        out_row_next   = row_reg;
        out_glyph_next = GLYPH_SPACE;
        out_last_next  = 1'b0;

        if (pre_step)
        begin
            // lone ESC drawn as a cell
            emit           = 1'b1;
            out_glyph_next = GLYPH_ESC;
            stage_next     = ST_MAIN;
            if (wrap)
            begin
                col_next = '0;
                if (at_bottom)
                    stage_next = ST_PRE_SCROLL;
                else
                    row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
            out_last_next = (stage_next == ST_MAIN) && !produces(head.op, row_next);
        end
        else if (stage_reg == ST_PRE_SCROLL)
        begin
            emit          = 1'b1;
            out_kind_next = KIND_SCROLL;
            out_col_next  = '0;
            out_row_next  = '0;
            out_glyph_next = '0;
            stage_next    = ST_MAIN;
            out_last_next = !produces(head.op, row_reg);
        end
        else if (stage_reg == ST_MAIN_SCROLL)
        begin
            emit           = 1'b1;
            out_kind_next  = KIND_SCROLL;
            out_col_next   = '0;
            out_row_next   = '0;
            out_glyph_next = '0;
            out_last_next  = 1'b1;
            done           = 1'b1;
        end
        else if (main_step)
        begin
            unique case (head.op)
                OP_NL:
                begin
                    col_next = '0;
                    done     = 1'b1;
                    if (at_bottom)
                    begin
                        emit           = 1'b1;
                        out_kind_next  = KIND_SCROLL;
                        out_col_next   = '0;
                        out_row_next   = '0;
                        out_glyph_next = '0;
                        out_last_next  = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                OP_BS:
                begin
                    // step left, or to the end of the row above
                    if (col_reg != '0)
                        col_next = col_reg - 1'b1;
                    else if (row_reg != '0)
                    begin
                        row_next = row_reg - 1'b1;
                        col_next = COL_W'(COLUMNS - 1);
                    end
                    emit          = 1'b1;
                    out_col_next  = col_next;
                    out_row_next  = row_next;
                    out_last_next = 1'b1;
                    done          = 1'b1;
                end
                OP_CLEAR:
                begin
                    emit           = 1'b1;
                    out_kind_next  = KIND_CLEAR;
                    out_col_next   = '0;
                    out_row_next   = '0;
                    out_glyph_next = '0;
                    out_last_next  = 1'b1;
                    col_next       = '0;
                    row_next       = ROW_W'(1);
                    done           = 1'b1;
                end
                OP_CHAR, OP_TAB:
                begin
                    emit           = 1'b1;
                    out_glyph_next = (head.op == OP_TAB) ? GLYPH_SPACE : head.glyph;
                    if (!put_end)
                    begin
                        // more tab spaces follow
                        col_next = col_inc[COL_W-1:0];
                        tab_next = tab_reg + 1'b1;
                    end
                    else if (wrap)
                    begin
                        col_next = '0;
                        if (at_bottom)
                            stage_next = ST_MAIN_SCROLL;
                        else
                        begin
                            row_next      = row_reg + 1'b1;
                            out_last_next = 1'b1;
                            done          = 1'b1;
                        end
                    end
                    else
                    begin
                        col_next      = col_inc[COL_W-1:0];
                        out_last_next = 1'b1;
                        done          = 1'b1;
                    end
                end
                default:
                begin
                    // nothing to draw
                    done = 1'b1;
                end
            endcase
        end

        if (done)
        begin
            stage_next = ST_HEAD;
            tab_next   = '0;
        end
    end

    // Cursor and sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= ROW_W'(1);
            stage_reg     <= ST_HEAD;
            tab_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                stage_reg <= stage_next;
                tab_reg   <= tab_next;
            end
            if (slot_free)
                out_valid_reg <= fire && emit;
        end
    end

    assign col_ext = COL_XW'(out_col_next);
    assign row_ext = ROW_XW'(out_row_next);

    // Output payload
    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_res_reg.kind        <= out_kind_next;
            out_res_reg.cell_col    <= col_ext[6:0];
            out_res_reg.cell_row    <= row_ext[5:0];
            out_res_reg.glyph_code  <= out_glyph_next;
            out_res_reg.fore_color  <= head.fore;
            out_res_reg.back_color  <= head.back;
            out_res_reg.last_of_run <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule
